// File: hw/rtl/rmts_pkg.sv
// Shared types and constants of the rate-monotonic tick scheduler.
package rmts_pkg;

  localparam int NUM_TASKS_DEF  = 4;
  localparam int TIME_WIDTH_DEF = 16;
  localparam int TASK_SLOTS     = 4;
  localparam int REG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int TASK_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PERIOD_BASE = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_WCET_BASE   = 3'd4;

  localparam logic [REG_WIDTH-1:0] PERIOD_RESET = '1;
  localparam logic [REG_WIDTH-1:0] WCET_RESET   = '0;

  typedef logic [TASK_IDX_WIDTH-1:0] task_idx_t;
  typedef logic [REG_WIDTH-1:0]      reg_t;

  typedef struct packed {
    task_idx_t run_task;
    logic      idle;
    logic      deadline_missed;
    task_idx_t missed_task;
  } result_t;

endpackage

// File: hw/rtl/rmts_tick_if.sv
// Request channel of the scheduler: one tick request per handshake.
interface rmts_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

// File: hw/rtl/rmts_result_if.sv
// Result channel of the scheduler: one scheduling decision per handshake.
interface rmts_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] run_task;
  logic       idle;
  logic       deadline_missed;
  logic [1:0] missed_task;

  modport source (output valid, output run_task, output idle, output deadline_missed,
                  output missed_task, input ready);
  modport sink (input valid, input run_task, input idle, input deadline_missed,
                input missed_task, output ready);
endinterface

// File: hw/rtl/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler for up to four periodic tasks.
//
// Usage: program period_0..3 (index 0..3) and wcet_0..3 (index 4..7) through
// the write port while the block is idle. Each request on req_i carries one
// tick bit; tick = 1 advances time one unit, tick = 0 only reports state.
// Every request produces exactly one result on rsp_o: the task run this
// tick (or idle) and the sticky deadline-miss flag with the missed task.
// The scheduling decision is computed in the cycle the request is taken and
// lands in the result register (or the skid entry), and throughput is
// one request per cycle. A two-entry result buffer (result register plus a
// skid entry) lets a request be taken while a finished result still waits;
// when the receiver stalls, req_i.ready drops once both entries are full.
// Reset clears all task state, loads period 65535 and wcet 0, and schedules
// a release of every task at the first tick. After a deadline miss the
// scheduler halts and reports idle with the miss flags until reset.
module rate_monotonic_tick_scheduler #(
  parameter int NUM_TASKS  = rmts_pkg::NUM_TASKS_DEF,
  parameter int TIME_WIDTH = rmts_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmts_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [rmts_pkg::REG_WIDTH-1:0]     cfg_data_i,
  rmts_tick_if.sink                         req_i,
  rmts_result_if.source                     rsp_o
);
  import rmts_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TIME_MASK = '1;

  typedef logic [TIME_WIDTH-1:0] time_t;

  reg_t      period_q [TASK_SLOTS];
  reg_t      wcet_q   [TASK_SLOTS];
  time_t     exec_q   [NUM_TASKS];
  time_t     exec_d   [NUM_TASKS];
  time_t     until_q  [NUM_TASKS];
  time_t     until_d  [NUM_TASKS];
  time_t     budget   [NUM_TASKS];
  time_t     reload   [NUM_TASKS];
  logic      first_q, first_d;
  logic      halted_q, halted_d;
  task_idx_t missed_q, missed_d;

  result_t   out_q, out_d, skid_q, skid_d, res;
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic      accept, out_fire;

  assign accept   = req_i.valid && req_i.ready;
  assign out_fire = out_valid_q && rsp_o.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        period_q[k] <= PERIOD_RESET;
        wcet_q[k]   <= WCET_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i >= CFG_WCET_BASE) begin
        wcet_q[TASK_IDX_WIDTH'(cfg_idx_i - CFG_WCET_BASE)] <= cfg_data_i;
      end else begin
        period_q[TASK_IDX_WIDTH'(cfg_idx_i - CFG_PERIOD_BASE)] <= cfg_data_i;
      end
    end
  end

  // Per-task budget and reload value
  always_comb begin
    reg_t p;
    for (int k = 0; k < NUM_TASKS; k++) begin
      p = (period_q[k] == '0) ? reg_t'(1) : period_q[k];
      reload[k] = TIME_WIDTH'(32'(p - reg_t'(1)));
      if (32'(wcet_q[k]) > 32'(TIME_MASK)) begin
        budget[k] = TIME_MASK;
      end else begin
        budget[k] = TIME_WIDTH'(32'(wcet_q[k]));
      end
    end
  end

  // Scheduling step
  always_comb begin
    logic      miss_found, run_found;
    task_idx_t miss_idx, run_idx;
    reg_t      miss_p, run_p;
    time_t     exec_n [NUM_TASKS];

    miss_found = 1'b0;
    miss_idx   = '0;
    miss_p     = '0;
    run_found  = 1'b0;
    run_idx    = '0;
    run_p      = '0;
    for (int k = 0; k < NUM_TASKS; k++) begin
      exec_d[k]  = exec_q[k];
      until_d[k] = until_q[k];
      exec_n[k]  = exec_q[k];
    end
    first_d  = first_q;
    halted_d = halted_q;
    missed_d = missed_q;

    if (accept && req_i.tick && !halted_q) begin
      if (!first_q) begin
        for (int k = 0; k < NUM_TASKS; k++) begin
          if (until_q[k] == '0 && exec_q[k] < budget[k] &&
              (!miss_found || period_q[k] < miss_p)) begin
            miss_found = 1'b1;
            miss_idx   = TASK_IDX_WIDTH'(k);
            miss_p     = period_q[k];
          end
        end
      end

      if (miss_found) begin
        halted_d = 1'b1;
        missed_d = miss_idx;
      end else begin
        for (int k = 0; k < NUM_TASKS; k++) begin
          if (until_q[k] == '0) begin
            exec_n[k]  = '0;
            until_d[k] = reload[k];
          end else begin
            until_d[k] = until_q[k] - time_t'(1);
          end
        end
        first_d = 1'b0;

        for (int k = 0; k < NUM_TASKS; k++) begin
          if (exec_n[k] < budget[k] && (!run_found || period_q[k] < run_p)) begin
            run_found = 1'b1;
            run_idx   = TASK_IDX_WIDTH'(k);
            run_p     = period_q[k];
          end
        end

        for (int k = 0; k < NUM_TASKS; k++) begin
          exec_d[k] = exec_n[k];
          if (run_found && run_idx == TASK_IDX_WIDTH'(k)) begin
            exec_d[k] = exec_n[k] + time_t'(1);
          end
        end
      end
    end

    res.run_task        = run_found ? run_idx : '0;
    res.idle            = !run_found;
    res.deadline_missed = halted_d;
    res.missed_task     = halted_d ? missed_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        exec_q[k]  <= '0;
        until_q[k] <= '0;
      end
      first_q  <= 1'b1;
      halted_q <= 1'b0;
      missed_q <= '0;
    end else begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        exec_q[k]  <= exec_d[k];
        until_q[k] <= until_d[k];
      end
      first_q  <= first_d;
      halted_q <= halted_d;
      missed_q <= missed_d;
    end
  end

  // Result register and skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign req_i.ready           = !skid_valid_q;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.run_task        = out_q.run_task;
  assign rsp_o.idle            = out_q.idle;
  assign rsp_o.deadline_missed = out_q.deadline_missed;
  assign rsp_o.missed_task     = out_q.missed_task;

endmodule

// File: test/tb.sv
// Testbench for the rate-monotonic tick scheduler: random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import rmts_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 64;
  localparam int SETTLE       = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int PLAN_TRIES   = 40;

  typedef logic [TIME_WIDTH_DEF-1:0] time_t;
  localparam time_t TIME_MAX = '1;

  typedef struct packed {
    reg_t [TASK_SLOTS-1:0] period;
    reg_t [TASK_SLOTS-1:0] wcet;
  } sched_cfg_t;

  typedef struct packed {
    time_t [TASK_SLOTS-1:0] executed;
    time_t [TASK_SLOTS-1:0] countdown;
    logic                   first_pending;
    logic                   halted;
    task_idx_t              missed;
  } sched_state_t;

  class decision_board;
    sched_cfg_t   cfg;
    sched_state_t st;
    result_t      awaited[$];
    int           checked;
    int           errors;

    function new();
      for (int k = 0; k < TASK_SLOTS; k++) begin
        cfg.period[k] = PERIOD_RESET;
        cfg.wcet[k]   = WCET_RESET;
      end
      st = '0;
      st.first_pending = 1'b1;
      checked = 0;
      errors  = 0;
    endfunction

    static function time_t job_budget(reg_t w);
      return (w > reg_t'(TIME_MAX)) ? TIME_MAX : time_t'(w);
    endfunction

    static function bit outranks(sched_cfg_t c, int a, int b);
      if (c.period[a] != c.period[b]) return c.period[a] < c.period[b];
      return a < b;
    endfunction

    static function result_t decide(inout sched_state_t s, input sched_cfg_t c,
                                    input logic tick);
      result_t r;
      int      miss;
      int      best;
      reg_t    p;
      r = '0;
      r.idle = 1'b1;
      miss = -1;
      best = -1;
      if (tick && !s.halted) begin
        if (!s.first_pending) begin
          for (int k = 0; k < NUM_TASKS_DEF; k++) begin
            if (s.countdown[k] == '0 && s.executed[k] < job_budget(c.wcet[k]))
              if (miss < 0 || outranks(c, k, miss)) miss = k;
          end
        end
        if (miss >= 0) begin
          s.halted = 1'b1;
          s.missed = task_idx_t'(miss);
        end else begin
          for (int k = 0; k < NUM_TASKS_DEF; k++) begin
            if (s.countdown[k] == '0) begin
              p = (c.period[k] == '0) ? reg_t'(1) : c.period[k];
              s.executed[k]  = '0;
              s.countdown[k] = time_t'(p - 1'b1);
            end else begin
              s.countdown[k] = s.countdown[k] - 1'b1;
            end
          end
          s.first_pending = 1'b0;
          for (int k = 0; k < NUM_TASKS_DEF; k++) begin
            if (s.executed[k] < job_budget(c.wcet[k]))
              if (best < 0 || outranks(c, k, best)) best = k;
          end
          if (best >= 0) begin
            s.executed[best] = s.executed[best] + 1'b1;
            r.run_task = task_idx_t'(best);
            r.idle     = 1'b0;
          end
        end
      end
      r.deadline_missed = s.halted;
      r.missed_task     = s.halted ? s.missed : '0;
      return r;
    endfunction

    function void note_request(logic tick);
      awaited.insert(awaited.size(), decide(st, cfg, tick));
    endfunction

    function void check_decision(result_t got);
      result_t want;
      checked++;
      if (awaited.size() == 0) begin
        $error("result with no tick request outstanding");
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.run_task != want.run_task) begin
        $error("run_task: expected %0d, got %0d", want.run_task, got.run_task);
        errors++;
      end
      if (got.idle != want.idle) begin
        $error("idle: expected %0d, got %0d", want.idle, got.idle);
        errors++;
      end
      if (got.deadline_missed != want.deadline_missed) begin
        $error("deadline_missed: expected %0d, got %0d", want.deadline_missed,
               got.deadline_missed);
        errors++;
      end
      if (got.missed_task != want.missed_task) begin
        $error("missed_task: expected %0d, got %0d", want.missed_task, got.missed_task);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i;
  reg_t                     cfg_data_i;

  rmts_tick_if   req_if ();
  rmts_result_if rsp_if ();

  decision_board board = new();
  bit            idling = 1'b1;
  bit            hold_req = 1'b0;
  int            requests_sent = 0;
  int            quiet_cycles = 0;

  rate_monotonic_tick_scheduler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin : monitor
    result_t got;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        board.note_request(req_if.tick);
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.run_task        = rsp_if.run_task;
        got.idle            = rsp_if.idle;
        got.deadline_missed = rsp_if.deadline_missed;
        got.missed_task     = rsp_if.missed_task;
        board.check_decision(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int n;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      n = 0;
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
      end
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_tick(input logic t);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.tick  <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (board.checked < requests_sent) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic load_config(input sched_cfg_t c);
    for (int k = 0; k < TASK_SLOTS; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_PERIOD_BASE + CFG_IDX_WIDTH'(k);
      cfg_data_i <= c.period[k];
      @(posedge clk_i);
      cfg_idx_i  <= CFG_WCET_BASE + CFG_IDX_WIDTH'(k);
      cfg_data_i <= c.wcet[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    board.cfg = c;
  endtask

  function automatic sched_cfg_t draw_config();
    sched_cfg_t c;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      c.period[k] = ($urandom_range(0, 15) == 0) ? '0 : reg_t'($urandom_range(1, 40));
      c.wcet[k]   = ($urandom_range(0, 3) == 0) ? '0
                  : reg_t'($urandom_range(0, (c.period[k] + 1) / 3));
    end
    return c;
  endfunction

  function automatic bit plan_is_safe(sched_state_t s, sched_cfg_t c, int ticks);
    for (int i = 0; i < ticks; i++) void'(decision_board::decide(s, c, 1'b1));
    return !s.halted;
  endfunction

  localparam logic [13:0] DIRECTED_TICKS = 14'b11011101111011;

  initial begin : stimulus
    sched_cfg_t c;
    logic       plan[$];
    int         ones;
    int         n;
    bit         safe;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.tick  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_tick(1'b0);
    send_tick(1'b0);
    drain_results();
    c = '0;
    c.period[0] = 5;
    c.period[1] = 2;
    c.period[2] = 2;
    c.wcet[0]   = 1;
    c.wcet[1]   = 1;
    load_config(c);
    for (int i = 13; i >= 0; i--) send_tick(DIRECTED_TICKS[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      idling = (ph < PHASES - 2);
      plan.delete();
      ones = 0;
      repeat (PHASE_ITEMS) begin
        plan.insert(plan.size(), $urandom_range(0, 7) != 0);
        ones += plan[$];
      end
      drain_results();
      safe = 1'b0;
      for (int t = 0; t < PLAN_TRIES && !safe; t++) begin
        c = draw_config();
        safe = plan_is_safe(board.st, c, ones);
      end
      if (!safe) c.wcet = '0;
      load_config(c);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 40) hold_req = 1'b1;
        if (ph == 3 && i == 75) drain_results();
        send_tick(plan[i]);
      end
    end

    // align all release countdowns to zero with no work pending
    drain_results();
    c = '0;
    for (int k = 0; k < TASK_SLOTS; k++) c.period[k] = 1;
    load_config(c);
    n = 0;
    for (int k = 0; k < TASK_SLOTS; k++)
      if (int'(board.st.countdown[k]) > n) n = int'(board.st.countdown[k]);
    repeat (n + 1) send_tick(1'b1);

    drain_results();
    c.period[0] = '1;
    load_config(c);
    send_tick(1'b1);
    send_tick(1'b0);

    // release tasks 1..3 together with unfinished work: simultaneous miss
    drain_results();
    c.wcet[0] = '1;
    for (int k = 1; k < TASK_SLOTS; k++) begin
      c.period[k] = reg_t'($urandom_range(0, 3));
      c.wcet[k]   = reg_t'($urandom_range(1, 65535));
    end
    c.wcet[$urandom_range(1, 3)] = '1;
    load_config(c);
    send_tick(1'b1);
    repeat (8) send_tick(logic'($urandom_range(0, 1)));

    drain_results();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
